### design/assert_macros.svh
// assertion macros used by the encoder's command queue
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
// condition must never be seen outside reset
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define ASSERT_AT(lbl, clk, rstn, prop, msg)
`define ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

### design/uule_pkg.sv
// shared types, constants and functions of the uuencode line encoder
package uule_pkg;

    localparam int CNT_W = 24;
    localparam int SUM_W = 18;
    localparam int BCD_DIGITS = 6;
    localparam int QDEPTH = 4;
    localparam int QAW = 2;

    localparam logic [5:0] C_LINE_BYTES = 6'd45;
    localparam logic [4:0] C_LINES_PER_SUM = 5'd20;
    localparam logic [4:0] C_DD_STEPS = 5'd18;
    localparam logic [7:0] C_NEWLINE = 8'h0A;
    localparam logic [7:0] C_DIGIT0 = 8'h30;
    localparam logic [7:0] C_ZERO_SYM = 8'h60;
    localparam logic [7:0] C_SYM_BASE = 8'h20;

    // one line-building command from the front to the back
    typedef struct packed {
        logic             has_len;
        logic [5:0]       len;
        logic             has_grp;
        logic [7:0]       b0;
        logic [7:0]       b1;
        logic [7:0]       b2;
        logic             has_nl;
        logic             has_sum;
        logic [SUM_W-1:0] sum;
    } t_cmd;

    // six-bit value to printable uuencode symbol
    function automatic logic [7:0] enc6(input logic [5:0] v);
        enc6 = (v == 6'd0) ? C_ZERO_SYM : ({2'b00, v} + C_SYM_BASE);
    endfunction

endpackage

### design/uule_front.sv
// front end: takes data bytes, tracks line and block state, issues commands
module uule_front
    import uule_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    input  logic [CNT_W-1:0] i_byte_count,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_data_byte,
    input  logic             i_full,
    output logic             o_push,
    output t_cmd             o_cmd
);

    logic [CNT_W-1:0] r_byte_count;
    logic [CNT_W-1:0] r_bytes_left, n_bytes_left;
    logic [5:0]       r_line_pos, n_line_pos;
    logic [7:0]       r_g0, n_g0, r_g1, n_g1;
    logic [1:0]       r_phase, n_phase;
    logic [SUM_W-1:0] r_sum, n_sum;
    logic [4:0]       r_lines, n_lines;

    logic             accept;
    logic [CNT_W-1:0] bl, bl_dec;
    logic [5:0]       lp, lp_inc;
    logic [1:0]       ph;
    logic [SUM_W-1:0] sum_add;
    logic [4:0]       lines_inc;
    logic             line_end;
    t_cmd             cmd;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    // next state and command for one accepted byte
    always_comb begin
        n_bytes_left = r_bytes_left;
        n_line_pos   = r_line_pos;
        n_g0         = r_g0;
        n_g1         = r_g1;
        n_phase      = r_phase;
        n_sum        = r_sum;
        n_lines      = r_lines;
        cmd          = '0;

        bl        = (r_bytes_left == '0) ? r_byte_count : r_bytes_left;
        lp        = (r_bytes_left == '0) ? 6'd0 : r_line_pos;
        ph        = (r_bytes_left == '0) ? 2'd0 : r_phase;
        bl_dec    = bl - 1'b1;
        lp_inc    = lp + 1'b1;
        sum_add   = r_sum + {{(SUM_W-8){1'b0}}, i_data_byte};
        lines_inc = r_lines + 1'b1;
        line_end  = (lp_inc >= C_LINE_BYTES) || (bl_dec == '0);

        if (bl != '0) begin
            // length symbol at line start
            cmd.has_len  = (lp == 6'd0) && (ph == 2'd0);
            cmd.len      = (bl < {{(CNT_W-6){1'b0}}, C_LINE_BYTES}) ? bl[5:0] : C_LINE_BYTES;
            n_sum        = sum_add;
            n_bytes_left = bl_dec;
            n_line_pos   = lp_inc;

            // hold byte or close the group
            if (ph != 2'd2 && !line_end) begin
                if (ph == 2'd0) begin
                    n_g0 = i_data_byte;
                end else begin
                    n_g1 = i_data_byte;
                end
                n_phase = ph + 1'b1;
            end else begin
                cmd.has_grp = 1'b1;
                cmd.b0 = (ph == 2'd0) ? i_data_byte : r_g0;
                cmd.b1 = (ph == 2'd0) ? 8'd0 : ((ph == 2'd1) ? i_data_byte : r_g1);
                cmd.b2 = (ph == 2'd2) ? i_data_byte : 8'd0;
                n_phase = 2'd0;
            end

            // line end, block sum
            if (line_end) begin
                cmd.has_nl = 1'b1;
                n_line_pos = 6'd0;
                cmd.sum    = sum_add;
                if (lines_inc >= C_LINES_PER_SUM ||
                    (bl_dec == '0 && lines_inc != 5'd0)) begin
                    cmd.has_sum = 1'b1;
                    n_sum       = '0;
                    n_lines     = 5'd0;
                end else begin
                    n_lines = lines_inc;
                end
            end
        end else begin
            n_bytes_left = '0;
            n_line_pos   = 6'd0;
            n_phase      = 2'd0;
        end
    end

    assign o_push = accept && (cmd.has_len || cmd.has_grp);
    assign o_cmd  = cmd;

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count <= '0;
            r_bytes_left <= '0;
            r_line_pos   <= '0;
            r_g0         <= '0;
            r_g1         <= '0;
            r_phase      <= '0;
            r_sum        <= '0;
            r_lines      <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_byte_count <= i_byte_count;
            end
            if (accept) begin
                r_bytes_left <= n_bytes_left;
                r_line_pos   <= n_line_pos;
                r_g0         <= n_g0;
                r_g1         <= n_g1;
                r_phase      <= n_phase;
                r_sum        <= n_sum;
                r_lines      <= n_lines;
            end
        end
    end

endmodule

### design/uule_queue.sv
// short command queue between front and back
`include "assert_macros.svh"
module uule_queue
    import uule_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_nonempty,
    output t_cmd o_head
);

    t_cmd           r_mem [QDEPTH];
    logic [QAW-1:0] r_wptr, r_rptr;
    logic [QAW:0]   r_count;

    assign o_full     = (r_count == QDEPTH[QAW:0]);
    assign o_nonempty = (r_count != '0);
    assign o_head     = r_mem[r_rptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_NEVER(a_push_full, i_clk, i_rst_n, i_push && o_full, "push into full queue")
    `ASSERT_NEVER(a_pop_empty, i_clk, i_rst_n, i_pop && !o_nonempty, "pop from empty queue")
    `ASSERT_AT(a_fill_up, i_clk, i_rst_n, (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1), "fill level missed a push")
    `ASSERT_AT(a_ptr_gap, i_clk, i_rst_n, (r_count == '0) || (r_count == QDEPTH[QAW:0]) || (r_wptr != r_rptr), "pointers disagree with fill level")

endmodule

### design/uule_back.sv
// back end: turns commands into characters, at most one per cycle as the receiver allows, with decimal sum text
module uule_back
    import uule_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cmd_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_out_char,
    output logic       o_run_last
);

    typedef enum logic [3:0] {
        S_IDLE, S_LEN, S_G0, S_G1, S_G2, S_G3, S_NL, S_CONV, S_DIG, S_SNL
    } t_step;

    t_step              r_step, n_step;
    t_cmd               r_cmd, n_cmd;
    logic [SUM_W-1:0]   r_bin, n_bin;
    logic [4*BCD_DIGITS-1:0] r_bcd, n_bcd;
    logic [4:0]         r_cnt, n_cnt;
    logic [2:0]         r_dig, n_dig;
    logic               r_ovalid, n_ovalid;
    logic [7:0]         r_ochar, n_ochar;
    logic               r_olast, n_olast;

    logic               load_ok, emit, last, take_next, pop;
    logic [7:0]         ch;
    logic [4*BCD_DIGITS-1:0] adj;
    logic [2:0]         top;
    logic [3:0]         nib;

    assign load_ok = !r_ovalid || i_ready;
    assign nib     = r_bcd[{r_dig, 2'b00} +: 4];

    // add-3 correction of every digit before the shift
    always_comb begin
        adj = r_bcd;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end
        end
    end

    // highest nonzero digit
    always_comb begin
        top = 3'd0;
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] != 4'd0) begin
                top = 3'(i);
            end
        end
    end

    // step sequencer
    always_comb begin
        n_step    = r_step;
        n_cmd     = r_cmd;
        n_bin     = r_bin;
        n_bcd     = r_bcd;
        n_cnt     = r_cnt;
        n_dig     = r_dig;
        n_ovalid  = r_ovalid && !i_ready;
        n_ochar   = r_ochar;
        n_olast   = r_olast;
        emit      = 1'b0;
        last      = 1'b0;
        ch        = C_NEWLINE;
        take_next = 1'b0;
        pop       = 1'b0;

        case (r_step)
            S_IDLE: begin
                take_next = 1'b1;
            end
            S_LEN: begin
                emit = 1'b1;
                ch   = enc6(r_cmd.len);
                last = !r_cmd.has_grp;
                if (load_ok) begin
                    n_step = S_G0;
                end
            end
            S_G0: begin
                emit = 1'b1;
                ch   = enc6(r_cmd.b0[7:2]);
                if (load_ok) begin
                    n_step = S_G1;
                end
            end
            S_G1: begin
                emit = 1'b1;
                ch   = enc6({r_cmd.b0[1:0], r_cmd.b1[7:4]});
                if (load_ok) begin
                    n_step = S_G2;
                end
            end
            S_G2: begin
                emit = 1'b1;
                ch   = enc6({r_cmd.b1[3:0], r_cmd.b2[7:6]});
                if (load_ok) begin
                    n_step = S_G3;
                end
            end
            S_G3: begin
                emit = 1'b1;
                ch   = enc6(r_cmd.b2[5:0]);
                last = !r_cmd.has_nl;
                if (load_ok) begin
                    n_step = S_NL;
                end
            end
            S_NL: begin
                emit = 1'b1;
                ch   = C_NEWLINE;
                last = !r_cmd.has_sum;
                if (load_ok) begin
                    n_step = S_CONV;
                    n_bin  = r_cmd.sum;
                    n_bcd  = '0;
                    n_cnt  = 5'd0;
                end
            end
            S_CONV: begin
                // one shift-add-3 step a cycle, then pick the digit count
                if (r_cnt != C_DD_STEPS) begin
                    n_bcd = {adj[4*BCD_DIGITS-2:0], r_bin[SUM_W-1]};
                    n_bin = {r_bin[SUM_W-2:0], 1'b0};
                    n_cnt = r_cnt + 1'b1;
                end else begin
                    n_dig  = top;
                    n_step = S_DIG;
                end
            end
            S_DIG: begin
                emit = 1'b1;
                ch   = C_DIGIT0 + {4'd0, nib};
                if (load_ok) begin
                    if (r_dig == 3'd0) begin
                        n_step = S_SNL;
                    end else begin
                        n_dig = r_dig - 1'b1;
                    end
                end
            end
            S_SNL: begin
                emit = 1'b1;
                ch   = C_NEWLINE;
                last = 1'b1;
            end
            default: begin
                n_step = S_IDLE;
            end
        endcase

        // load the output register
        if (emit && load_ok) begin
            n_ovalid = 1'b1;
            n_ochar  = ch;
            n_olast  = last;
            if (last) begin
                take_next = 1'b1;
            end
        end

        // fetch the next command
        if (take_next) begin
            if (i_cmd_valid) begin
                pop    = 1'b1;
                n_cmd  = i_cmd;
                n_step = i_cmd.has_len ? S_LEN : S_G0;
            end else begin
                n_step = S_IDLE;
            end
        end
    end

    assign o_pop      = pop;
    assign o_valid    = r_ovalid;
    assign o_out_char = r_ochar;
    assign o_run_last = r_olast;

    // state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= S_IDLE;
            r_ovalid <= 1'b0;
            r_cnt    <= '0;
            r_dig    <= '0;
        end else begin
            r_step   <= n_step;
            r_ovalid <= n_ovalid;
            r_cnt    <= n_cnt;
            r_dig    <= n_dig;
        end
        r_cmd   <= n_cmd;
        r_bin   <= n_bin;
        r_bcd   <= n_bcd;
        r_ochar <= n_ochar;
        r_olast <= n_olast;
    end

endmodule

### design/uuencode_line_checksum_encoder.sv
// top level of the uuencode line encoder with per-block decimal byte sums
//
// Usage: write the transfer length to i_byte_count (i_cfg_valid, always ready)
// while the block is idle, then send data bytes on i_valid/o_ready with
// i_data_byte. Characters come out on o_valid/i_ready as o_out_char, and
// o_run_last marks the last character that one data byte causes.
// A front end updates line and block state for one byte a cycle while the
// queue is not full, and puts a command into a four-entry queue when a line
// starts or a group closes; a back end turns each command into characters
// at most one a cycle through an output register that holds while stalled.
// A byte's command passes the queue, the back end's command register and
// the output register before its first character appears. A 45-byte line
// gives 62 characters, and each block sum goes through a binary-to-decimal
// conversion in the back end before its digits.
// Reset clears control state and the length register, not the queue or
// back-end data registers. When the receiver stalls, the output word holds,
// the queue fills and o_ready drops once it is full; no character is lost.
module uuencode_line_checksum_encoder
    import uule_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [CNT_W-1:0] i_byte_count,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_data_byte,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [7:0]       o_out_char,
    output logic             o_run_last
);

    logic q_full, q_push, q_pop, q_nonempty;
    t_cmd q_in, q_head;

    assign o_cfg_ready = 1'b1;

    // byte front end
    uule_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_byte_count (i_byte_count),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_data_byte  (i_data_byte),
        .i_full       (q_full),
        .o_push       (q_push),
        .o_cmd        (q_in)
    );

    // command queue
    uule_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (q_push),
        .i_cmd      (q_in),
        .o_full     (q_full),
        .i_pop      (q_pop),
        .o_nonempty (q_nonempty),
        .o_head     (q_head)
    );

    // character back end
    uule_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (q_nonempty),
        .i_cmd       (q_head),
        .o_pop       (q_pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_out_char  (o_out_char),
        .o_run_last  (o_run_last)
    );

endmodule
